[hw/rtl/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants for the lru key/value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;
  localparam int Entries  = 64;
  localparam int IdxW     = $clog2(Entries);
  localparam int CntW     = $clog2(Entries + 1);
  localparam int CapW     = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;
  localparam logic [31:0] MissValue = 32'hFFFF_FFFF;

  localparam logic OpGet = 1'b0;
  localparam logic OpSet = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request and run compare
    logic update;   // apply hit touch / overwrite / insert
  } lkvc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op;
  } lkvc_sts_t;
endpackage

[hw/rtl/lkvc_if.sv]
// ----------------------------------------------------------------------------
// lkvc_req_if / lkvc_rsp_if / lkvc_cfg_if
// valid/ready channels of the cache
// ----------------------------------------------------------------------------
interface lkvc_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] key;
  logic signed [31:0] value;
  modport source (output valid, op, key, value, input ready);
  modport sink   (input valid, op, key, value, output ready);
endinterface

interface lkvc_rsp_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] read_value;
  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

interface lkvc_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/lkvc_datapath.sv]
// ----------------------------------------------------------------------------
// lkvc_datapath
// entry registers, parallel key compare, rank update and victim select
// ----------------------------------------------------------------------------
module lkvc_datapath import lkvc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lkvc_cmd_t          cmd,
  output lkvc_sts_t          sts,
  input  logic               in_op,
  input  logic [31:0]        in_key,
  input  logic [31:0]        in_value,
  input  logic [CapW-1:0]    capacity,
  output logic               found,
  output logic [31:0]        read_value
);
  logic [31:0]     key_store   [Entries];
  logic [31:0]     value_store [Entries];
  logic            valid_bits  [Entries];
  logic [IdxW-1:0] rank        [Entries];
  logic [CntW-1:0] count;

  // request registers and compare results
  logic            op;
  logic [31:0]     key;
  logic [31:0]     value;
  logic            hit;
  logic [IdxW-1:0] hit_idx;
  logic [IdxW-1:0] hit_rank;
  logic            free_any;
  logic [IdxW-1:0] free_idx;
  logic            victim_any;
  logic [IdxW-1:0] victim_idx;
  logic [CntW-1:0] cap_eff;

  logic            m_hit;
  logic [IdxW-1:0] m_idx;
  logic            m_free;
  logic [IdxW-1:0] m_fidx;
  logic            m_vic;
  logic [IdxW-1:0] m_vidx;

  assign sts.op = op;

  always_comb begin
    m_hit  = 1'b0;
    m_idx  = '0;
    m_free = 1'b0;
    m_fidx = '0;
    m_vic  = 1'b0;
    m_vidx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid_bits[i] && key_store[i] == in_key) begin
        m_hit = 1'b1;
        m_idx = IdxW'(i);
      end
      if (!valid_bits[i]) begin
        m_free = 1'b1;
        m_fidx = IdxW'(i);
      end
      // valid ranks are distinct, so the oldest has rank count-1
      if (valid_bits[i] && CntW'(rank[i]) == count - CntW'(1)) begin
        m_vic  = 1'b1;
        m_vidx = IdxW'(i);
      end
    end
  end

  always_comb begin
    cap_eff = (capacity == '0) ? CntW'(1)
            : (CntW'(capacity) > CntW'(Entries)) ? CntW'(Entries) : CntW'(capacity);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= in_op;
      key        <= in_key;
      value      <= in_value;
      hit        <= m_hit;
      hit_idx    <= m_idx;
      hit_rank   <= rank[m_idx];
      free_any   <= m_free;
      free_idx   <= m_fidx;
      victim_any <= m_vic;
      victim_idx <= m_vidx;
      found      <= m_hit;
      read_value <= m_hit ? value_store[m_idx] : MissValue;
    end
  end

  // valid entries younger than the pivot age by one; insert ages all
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Entries; i++) begin
        valid_bits[i] <= 1'b0;
        rank[i]       <= '0;
      end
      count <= '0;
    end else if (cmd.update) begin
      if (hit) begin
        for (int i = 0; i < Entries; i++)
          if (valid_bits[i] && rank[i] < hit_rank) rank[i] <= rank[i] + 1'b1;
        rank[hit_idx] <= '0;
        if (op == OpSet) value_store[hit_idx] <= value;
      end else if (op == OpSet) begin
        if (count >= cap_eff || !free_any) begin
          if (victim_any) begin
            for (int i = 0; i < Entries; i++)
              if (valid_bits[i] && rank[i] < rank[victim_idx]) rank[i] <= rank[i] + 1'b1;
            rank[victim_idx]        <= '0;
            key_store[victim_idx]   <= key;
            value_store[victim_idx] <= value;
          end
        end else begin
          for (int i = 0; i < Entries; i++)
            if (valid_bits[i]) rank[i] <= rank[i] + 1'b1;
          rank[free_idx]        <= '0;
          key_store[free_idx]   <= key;
          value_store[free_idx] <= value;
          valid_bits[free_idx]  <= 1'b1;
          count                 <= count + CntW'(1);
        end
      end
    end
  end
endmodule

[hw/rtl/lkvc_ctrl.sv]
// ----------------------------------------------------------------------------
// lkvc_ctrl
// request sequencing: compare, update, response
// ----------------------------------------------------------------------------
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output lkvc_cmd_t cmd,
  input  lkvc_sts_t sts
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SUpd  = 2'd1;
  localparam logic [1:0] SRsp  = 2'd2;

  logic [1:0] state, state_next;

  assign req_ready  = (state == SIdle);
  assign rsp_valid  = (state == SRsp);
  assign cmd.load   = req_valid && req_ready;
  assign cmd.update = (state == SUpd);

  always_comb begin
    state_next = state;
    case (state)
      SIdle: if (req_valid) state_next = SUpd;
      SUpd:  state_next = (sts.op == OpGet) ? SRsp : SIdle;
      SRsp:  if (rsp_ready) state_next = SIdle;
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SIdle;
    else     state <= state_next;
  end
endmodule

[hw/rtl/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key/value store with lru replacement
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | op, key, value
//  rsp     | out | found, read_value (get only)
//  cfg     | in  | capacity (7 bits)
// a set runs a compare, then a rank/entry update; a get adds a
// response step; the compare result is registered before the update,
// and a new request is taken only after the last one is through.
// reset clears valid bits, ranks, occupancy; capacity returns to 64.
// a stalled response holds off the next request.
module lru_key_value_cache import lkvc_pkg::*; (
  input logic        clk,
  input logic        rst,
  lkvc_req_if.sink   req,
  lkvc_rsp_if.source rsp,
  lkvc_cfg_if.sink   cfg
);
  lkvc_cmd_t       cmd;
  lkvc_sts_t       sts;
  logic [CapW-1:0] capacity;
  logic [31:0]     rv;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) capacity <= CapReset;
    else if (cfg.valid) capacity <= cfg.data;
  end

  lkvc_ctrl u_ctrl (
    .clk, .rst,
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .cmd, .sts
  );

  lkvc_datapath u_dp (
    .clk, .rst, .cmd, .sts,
    .in_op(req.op), .in_key(req.key), .in_value(req.value),
    .capacity, .found(rsp.found), .read_value(rv)
  );
  assign rsp.read_value = rv;
endmodule
